// ===== rtl/swbd_pkg.sv =====
// Shared types and constants for the sync word bit deframer.
package swbd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_LENGTH      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_PATTERN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLYWHEEL_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_SEQUENTIAL = 3'd4;

   localparam logic [15:0] RST_FRAME_LENGTH     = 16'd10232;
   localparam logic [5:0]  RST_SYNC_LENGTH      = 6'd32;
   localparam logic [31:0] RST_SYNC_PATTERN     = 32'h1ACF_FC1D;
   localparam logic [2:0]  RST_FLYWHEEL_LIMIT   = 3'd5;
   localparam logic        RST_ALLOW_SEQUENTIAL = 1'b1;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [5:0]  sync_length;
      logic [31:0] sync_pattern;
      logic [2:0]  flywheel_limit;
      logic        allow_sequential;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_of_frame;
   } result_type;

endpackage

// ===== rtl/swbd_csr.sv =====
// Configuration register file for the sync word bit deframer.
module swbd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [swbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [swbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output swbd_pkg::cfg_type                 cfg
);

   swbd_pkg::cfg_type cfg_ff;
   swbd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            swbd_pkg::CSR_FRAME_LENGTH:     cfg_in.frame_length     = csr_wdata[15:0];
            swbd_pkg::CSR_SYNC_LENGTH:      cfg_in.sync_length      = csr_wdata[5:0];
            swbd_pkg::CSR_SYNC_PATTERN:     cfg_in.sync_pattern     = csr_wdata[31:0];
            swbd_pkg::CSR_FLYWHEEL_LIMIT:   cfg_in.flywheel_limit   = csr_wdata[2:0];
            swbd_pkg::CSR_ALLOW_SEQUENTIAL: cfg_in.allow_sequential = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length     <= swbd_pkg::RST_FRAME_LENGTH;
         cfg_ff.sync_length      <= swbd_pkg::RST_SYNC_LENGTH;
         cfg_ff.sync_pattern     <= swbd_pkg::RST_SYNC_PATTERN;
         cfg_ff.flywheel_limit   <= swbd_pkg::RST_FLYWHEEL_LIMIT;
         cfg_ff.allow_sequential <= swbd_pkg::RST_ALLOW_SEQUENTIAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/swbd_core.sv =====
// Deframer state: bit window, sync compare, flywheel and byte packing.
module swbd_core #(
   parameter int MAX_SYNC_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 bit_in,
   input  swbd_pkg::cfg_type    cfg,
   output swbd_pkg::result_type result
);

   localparam int LW = $clog2(MAX_SYNC_BITS);
   localparam int PW = (MAX_SYNC_BITS > 32) ? MAX_SYNC_BITS : 32;

   logic [MAX_SYNC_BITS-1:0] window_ff, window_in;
   logic                     in_frame_ff, in_frame_in;
   logic [15:0]              count_ff, count_in;
   logic [7:0]               acc_ff, acc_in;
   logic [2:0]               blind_ff, blind_in;
   logic                     expect_ff, expect_in;

   logic [6:0]               len_ext;
   logic [6:0]               lenm1_wide;
   logic [LW-1:0]            lenm1;
   logic [MAX_SYNC_BITS-1:0] mask;
   logic [PW-1:0]            pat_wide;
   logic [MAX_SYNC_BITS-1:0] pat_ext;
   logic                     match;
   logic                     judged;
   logic                     start;
   logic                     take_bit;
   logic [15:0]              cnt_base;
   logic [15:0]              cnt_new;
   logic [7:0]               acc_base;
   logic [7:0]               acc_new;
   logic [2:0]               bit_pos;

   always_comb begin
      len_ext = 7'(cfg.sync_length);
      if (len_ext == 7'd0) begin
         lenm1_wide = 7'd0;
      end else if (len_ext > 7'(MAX_SYNC_BITS)) begin
         lenm1_wide = 7'(MAX_SYNC_BITS - 1);
      end else begin
         lenm1_wide = len_ext - 7'd1;
      end
      lenm1 = LW'(lenm1_wide);
      for (int i = 0; i < MAX_SYNC_BITS; i++) begin
         mask[i] = (7'(i) <= lenm1_wide);
      end
   end

   assign window_in = {window_ff[MAX_SYNC_BITS-2:0], bit_in};
   assign pat_wide  = PW'(cfg.sync_pattern);
   assign pat_ext   = pat_wide[MAX_SYNC_BITS-1:0];
   assign match     = ((window_in ^ pat_ext) & mask) == '0;
   assign judged    = window_in[lenm1];

   always_comb begin
      blind_in  = blind_ff;
      expect_in = expect_ff;
      start     = 1'b0;
      if (!in_frame_ff) begin
         if (match) begin
            blind_in = 3'd0;
            start    = 1'b1;
         end else if (expect_ff) begin
            expect_in = 1'b0;
            if (blind_ff < cfg.flywheel_limit) begin
               blind_in = blind_ff + 3'd1;
               start    = 1'b1;
            end
         end
      end
      take_bit = in_frame_ff || start;
      cnt_base = in_frame_ff ? count_ff : 16'd0;
      acc_base = in_frame_ff ? acc_ff : 8'd0;
      bit_pos  = ~cnt_base[2:0];
      acc_new  = acc_base;
      acc_new[bit_pos] = acc_base[bit_pos] | judged;
      cnt_new  = cnt_base + 16'd1;

      in_frame_in          = in_frame_ff;
      count_in             = count_ff;
      acc_in               = acc_ff;
      result.valid         = 1'b0;
      result.data_byte     = acc_new;
      result.last_of_frame = 1'b0;
      if (take_bit) begin
         in_frame_in = 1'b1;
         count_in    = cnt_new;
         acc_in      = acc_new;
         if (cnt_new >= cfg.frame_length) begin
            result.valid         = 1'b1;
            result.last_of_frame = 1'b1;
            acc_in               = 8'd0;
            count_in             = 16'd0;
            in_frame_in          = 1'b0;
            if (cfg.allow_sequential) begin
               expect_in = 1'b1;
            end
         end else if (cnt_new[2:0] == 3'd0) begin
            result.valid = 1'b1;
            acc_in       = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         in_frame_ff <= 1'b0;
         count_ff    <= 16'd0;
         acc_ff      <= 8'd0;
         blind_ff    <= 3'd0;
         expect_ff   <= 1'b0;
      end else if (enable) begin
         window_ff   <= window_in;
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         acc_ff      <= acc_in;
         blind_ff    <= blind_in;
         expect_ff   <= expect_in;
      end
   end

endmodule

// ===== rtl/sync_word_bit_deframer_top.sv =====
// Top level of the sync word bit deframer: input register, core, result register.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_bit_in
//   rsp      out        rsp_valid / rsp_stall     rsp_data_byte, rsp_last_of_frame
//   csr      in         csr_wr_en                 csr_index, csr_wdata
//
// One item per cycle unless stalled; bits pass input register, core, result register.
// The core state updates in one pass between the input and result registers.
// Synchronous reset clears all control state and restores register defaults.
// rsp_stall holds a valid result register and, once the input register is full,
// raises req_stall in the same cycle.
module sync_word_bit_deframer_top #(
   parameter int MAX_SYNC_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_bit_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_data_byte,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_wr_en,
   input  logic [swbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [swbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   swbd_pkg::cfg_type    cfg;
   swbd_pkg::result_type result;

   logic       s1_valid_ff;
   logic       s1_bit_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   swbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swbd_core #(
      .MAX_SYNC_BITS (MAX_SYNC_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .bit_in (s1_bit_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_bit_ff <= req_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= result.data_byte;
         rsp_last_ff <= result.last_of_frame;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_data_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule
